>>> rtl/tmq_pkg.sv
// Shared constants and codes of the tiny MLP Q-learner.
package tmq_pkg;

    localparam int HIDDEN_UNITS_DEF = 16;
    localparam int ACTION_COUNT_DEF = 4;

    localparam int REQ_W    = 2;
    localparam int DATA_W   = 16;
    localparam int ACT_W    = 4;
    localparam int WIDX_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [15:0] EPS_RESET = 16'hFFFF;
    localparam logic [15:0] EPS_FLOOR = 16'd3276;
    localparam logic [31:0] EPS_DECAY = 32'd65503;

    typedef enum logic [REQ_W-1:0] {
        REQ_CHOOSE = 2'd0,
        REQ_TRAIN  = 2'd1,
        REQ_WRITE  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_TEMP = 3'd0,
        CFG_TEMP_SCALE  = 3'd1,
        CFG_POWER_LIMIT = 3'd2,
        CFG_POWER_SCALE = 3'd3,
        CFG_LEARN_RATE  = 3'd4
    } t_cfg_idx;

endpackage

>>> rtl/tmq_in_if.sv
// Request channel of the tiny MLP Q-learner.
interface tmq_in_if;
    logic                              valid;
    logic                              ready;
    logic [tmq_pkg::REQ_W-1:0]         req_type;
    logic signed [tmq_pkg::DATA_W-1:0] temperature;
    logic signed [tmq_pkg::DATA_W-1:0] power;
    logic [tmq_pkg::ACT_W-1:0]         taken_action;
    logic signed [tmq_pkg::DATA_W-1:0] reward;
    logic [tmq_pkg::DATA_W-1:0]        random_fraction;
    logic [tmq_pkg::ACT_W-1:0]         random_action;
    logic [tmq_pkg::WIDX_W-1:0]        weight_index;
    logic signed [tmq_pkg::DATA_W-1:0] weight_value;

    modport source (output valid, req_type, temperature, power, taken_action, reward,
                    random_fraction, random_action, weight_index, weight_value,
                    input ready);
    modport sink (input valid, req_type, temperature, power, taken_action, reward,
                  random_fraction, random_action, weight_index, weight_value,
                  output ready);
endinterface

>>> rtl/tmq_out_if.sv
// Result channel of the tiny MLP Q-learner.
interface tmq_out_if;
    logic                              valid;
    logic                              ready;
    logic [tmq_pkg::ACT_W-1:0]         chosen_action;
    logic signed [tmq_pkg::DATA_W-1:0] q_value;
    logic                              explored;

    modport source (output valid, chosen_action, q_value, explored, input ready);
    modport sink (input valid, chosen_action, q_value, explored, output ready);
endinterface

>>> rtl/tiny_mlp_q_learner.sv
// Top level of the tiny MLP Q-learner: sequencer, shared multiplier, hidden memory.
//
//  channel  | dir | handshake            | payload
//  i_in     | in  | valid/ready          | request: type, sensors, action, reward, draws, weight
//  o_out    | out | valid/ready          | chosen_action, q_value, explored
//  i_cfg_*  | in  | write enable only    | register index, data
//
// For a choose request one shared multiplier and one weight memory read port walk every
// weight of the forward pass. A train request adds the read-modify-write of each updated
// weight. One request is in flight at a time; the output register lets a new request
// enter while the last result waits. Reset is synchronous; weights are not cleared and
// must be loaded before use.
module tiny_mlp_q_learner #(
    parameter int HIDDEN_UNITS = tmq_pkg::HIDDEN_UNITS_DEF,
    parameter int ACTION_COUNT = tmq_pkg::ACTION_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tmq_in_if.sink                          i_in,
    tmq_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [tmq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tmq_pkg::DATA_W-1:0]      i_cfg_data
);
    localparam int H        = HIDDEN_UNITS;
    localparam int A        = ACTION_COUNT;
    localparam int BASE_B1  = 2 * H;
    localparam int BASE_W2  = 3 * H;
    localparam int BASE_B2  = 3 * H + H * A;
    localparam int TOTAL    = 3 * H + H * A + A;
    localparam int AW       = $clog2(TOTAL);
    localparam int JW       = $clog2(H + 1);
    localparam int HIW      = (H > 1) ? $clog2(H) : 1;
    localparam int KCW      = $clog2(A + 1);
    localparam int KW       = $clog2(A);
    localparam int ACCW     = 40;
    localparam int PW       = 56;

    typedef enum logic [28:0] {
        S_IDLE = 29'b1 << 0,  S_T0  = 29'b1 << 1,  S_T1  = 29'b1 << 2,
        S_T2   = 29'b1 << 3,  S_HB  = 29'b1 << 4,  S_HW0 = 29'b1 << 5,
        S_HW1  = 29'b1 << 6,  S_HW2 = 29'b1 << 7,  S_HW3 = 29'b1 << 8,
        S_OB   = 29'b1 << 9,  S_OA  = 29'b1 << 10, S_OM  = 29'b1 << 11,
        S_OF   = 29'b1 << 12, S_DEC = 29'b1 << 13, S_L0  = 29'b1 << 14,
        S_L1   = 29'b1 << 15, S_W2R = 29'b1 << 16, S_W2M = 29'b1 << 17,
        S_W2W  = 29'b1 << 18, S_G   = 29'b1 << 19, S_G2  = 29'b1 << 20,
        S_G3   = 29'b1 << 21, S_M0  = 29'b1 << 22, S_W0  = 29'b1 << 23,
        S_M1   = 29'b1 << 24, S_W1  = 29'b1 << 25, S_BW  = 29'b1 << 26,
        S_EPS  = 29'b1 << 27, S_DONE = 29'b1 << 28
    } t_state;

    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] v,
                                                 input int unsigned s);
        logic signed [63:0] bias;
        bias = 64'sd1 <<< (s - 1);
        return (v + bias) >>> s;
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [63:0] v);
        logic signed [15:0] res;
        if (v > 64'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    t_state r_state, n_state;

    logic signed [15:0] r_ctr;
    logic [15:0]        r_tsc;
    logic [14:0]        r_plim;
    logic [15:0]        r_psc;
    logic [15:0]        r_lr;
    logic [15:0]        r_eps, n_eps;

    logic [1:0]         r_req, n_req;
    logic signed [15:0] r_temp, n_temp;
    logic signed [15:0] r_pwr, n_pwr;
    logic [3:0]         r_act, n_act;
    logic signed [15:0] r_reward, n_reward;
    logic [15:0]        r_rfrac, n_rfrac;
    logic [KW-1:0]      r_tgt, n_tgt;

    logic signed [15:0] r_in0, n_in0;
    logic signed [15:0] r_in1, n_in1;
    logic [JW-1:0]      r_j, n_j;
    logic [KCW-1:0]     r_k, n_k;
    logic signed [ACCW-1:0] r_acc, n_acc;
    logic signed [PW-1:0]   r_prod;
    logic               r_rv, n_rv, r_pv, n_pv;
    logic [KW-1:0]      r_best, n_best;
    logic signed [15:0] r_bestq, n_bestq;
    logic signed [15:0] r_selq, n_selq;
    logic signed [16:0] r_err, n_err;
    logic signed [33:0] r_le, n_le;
    logic signed [15:0] r_wold, n_wold;
    logic signed [15:0] r_wnew, n_wnew;
    logic [14:0]        r_h, n_h;
    logic signed [37:0] r_lg, n_lg;

    logic [3:0]         r_res_act, n_res_act;
    logic signed [15:0] r_res_q, n_res_q;
    logic               r_res_exp, n_res_exp;

    logic               r_ov, n_ov;
    logic [3:0]         r_oact, n_oact;
    logic signed [15:0] r_oq, n_oq;
    logic               r_oexp, n_oexp;

    logic signed [37:0] mul_a;
    logic signed [17:0] mul_b;

    logic               mem_we;
    logic [AW-1:0]      mem_wa, mem_ra;
    logic signed [15:0] mem_wd, mem_rd;

    logic [14:0]        r_hid_mem [H];
    logic [14:0]        r_hid_rd;
    logic               hid_we;
    logic [HIW-1:0]     hid_wa, hid_ra;
    logic [14:0]        hid_wd;

    logic [HIW-1:0]     rj;
    logic [AW-1:0]      w2_addr;
    logic [4:0]         rmod;
    logic               in_acc;

    assign rj     = r_j[HIW-1:0];
    assign in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid         = r_ov;
    assign o_out.chosen_action = r_oact;
    assign o_out.q_value       = r_oq;
    assign o_out.explored      = r_oexp;

    always_comb begin
        logic [KW-1:0] kk;
        kk = (r_state == S_OM) ? r_k[KW-1:0] : r_tgt;
        w2_addr = AW'(BASE_W2) + AW'(AW'(rj) * AW'(A)) + AW'(kk);
    end

    always_comb begin
        rmod = {1'b0, i_in.random_action};
        for (int i = 0; i < 8; i++) begin
            if (rmod >= 5'(A)) begin
                rmod = rmod - 5'(A);
            end
        end
    end

    tmq_wram #(.DEPTH(TOTAL), .AW(AW)) u_wram (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_ra  (mem_ra),
        .o_rd  (mem_rd)
    );

    always_ff @(posedge i_clk) begin
        if (hid_we) begin
            r_hid_mem[hid_wa] <= hid_wd;
        end
        r_hid_rd <= r_hid_mem[hid_ra];
    end

    always_comb begin
        logic signed [16:0] diff;
        logic signed [16:0] lim;
        logic signed [15:0] pcl;
        logic signed [63:0] t64;
        logic signed [63:0] sum;
        logic signed [15:0] q16;
        logic signed [21:0] grad;
        logic               expl;

        n_state = r_state;   n_eps = r_eps;
        n_req = r_req;       n_temp = r_temp;     n_pwr = r_pwr;
        n_act = r_act;       n_reward = r_reward; n_rfrac = r_rfrac;
        n_tgt = r_tgt;       n_in0 = r_in0;       n_in1 = r_in1;
        n_j = r_j;           n_k = r_k;           n_acc = r_acc;
        n_rv = r_rv;         n_pv = r_pv;         n_best = r_best;
        n_bestq = r_bestq;   n_selq = r_selq;     n_err = r_err;
        n_le = r_le;         n_wold = r_wold;     n_wnew = r_wnew;
        n_h = r_h;           n_lg = r_lg;
        n_res_act = r_res_act; n_res_q = r_res_q; n_res_exp = r_res_exp;
        n_ov = r_ov;         n_oact = r_oact;     n_oq = r_oq;   n_oexp = r_oexp;
        mul_a = '0;          mul_b = '0;
        mem_we = 1'b0;       mem_wa = w2_addr;    mem_wd = '0;   mem_ra = w2_addr;
        hid_we = 1'b0;       hid_wa = rj;         hid_wd = '0;   hid_ra = rj;
        diff = '0;           lim = '0;            pcl = '0;      t64 = '0;
        sum = '0;            q16 = '0;            grad = '0;     expl = 1'b0;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req = i_in.req_type;
                    n_temp = i_in.temperature;
                    n_pwr = i_in.power;
                    n_act = i_in.taken_action;
                    n_reward = i_in.reward;
                    n_rfrac = i_in.random_fraction;
                    n_res_act = i_in.taken_action;
                    n_res_q = '0;
                    n_res_exp = 1'b0;
                    if (i_in.req_type == tmq_pkg::REQ_CHOOSE) begin
                        n_tgt = rmod[KW-1:0];
                        n_state = S_T0;
                    end else if (i_in.req_type == tmq_pkg::REQ_TRAIN &&
                                 32'(i_in.taken_action) < 32'(A)) begin
                        n_tgt = i_in.taken_action[KW-1:0];
                        n_state = S_T0;
                    end else begin
                        if (i_in.req_type == tmq_pkg::REQ_WRITE &&
                            32'(i_in.weight_index) < 32'(TOTAL)) begin
                            mem_we = 1'b1;
                            mem_wa = AW'(i_in.weight_index);
                            mem_wd = i_in.weight_value;
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_T0: begin
                diff = {r_temp[15], r_temp} - {r_ctr[15], r_ctr};
                mul_a = 38'(diff);
                mul_b = $signed({2'b00, r_tsc});
                n_state = S_T1;
            end
            S_T1: begin
                t64 = f_rnd(64'(r_prod), 4);
                if (t64 > 64'sd4096) begin
                    n_in0 = 16'sd4096;
                end else if (t64 < -64'sd4096) begin
                    n_in0 = -16'sd4096;
                end else begin
                    n_in0 = t64[15:0];
                end
                lim = $signed({2'b00, r_plim});
                if (17'(r_pwr) > lim) begin
                    pcl = lim[15:0];
                end else if (17'(r_pwr) < -lim) begin
                    pcl = 16'(-lim);
                end else begin
                    pcl = r_pwr;
                end
                mul_a = 38'(pcl);
                mul_b = $signed({2'b00, r_psc});
                n_state = S_T2;
            end
            S_T2: begin
                n_in1 = f_sat16(f_rnd(64'(r_prod), 4));
                n_j = '0;
                n_state = S_HB;
            end
            S_HB: begin
                mem_ra = AW'(BASE_B1) + AW'(rj);
                n_state = S_HW0;
            end
            S_HW0: begin
                n_acc = ACCW'(mem_rd) <<< 12;
                mem_ra = AW'(rj);
                n_state = S_HW1;
            end
            S_HW1: begin
                mul_a = 38'(r_in0);
                mul_b = 18'(mem_rd);
                mem_ra = AW'(H) + AW'(rj);
                n_state = S_HW2;
            end
            S_HW2: begin
                n_acc = r_acc + ACCW'(r_prod);
                mul_a = 38'(r_in1);
                mul_b = 18'(mem_rd);
                n_state = S_HW3;
            end
            S_HW3: begin
                sum = f_rnd(64'(r_acc) + 64'(r_prod), 12);
                hid_we = 1'b1;
                if (sum < 64'sd0) begin
                    hid_wd = '0;
                end else if (sum > 64'sd32767) begin
                    hid_wd = 15'h7FFF;
                end else begin
                    hid_wd = sum[14:0];
                end
                n_j = JW'(r_j + 1'b1);
                if (r_j == JW'(H - 1)) begin
                    n_k = '0;
                    n_state = S_OB;
                end else begin
                    n_state = S_HB;
                end
            end
            S_OB: begin
                mem_ra = AW'(BASE_B2) + AW'(r_k[KW-1:0]);
                n_state = S_OA;
            end
            S_OA: begin
                n_acc = ACCW'(mem_rd) <<< 12;
                n_j = '0;
                n_rv = 1'b0;
                n_pv = 1'b0;
                n_state = S_OM;
            end
            S_OM: begin
                if (r_j != JW'(H)) begin
                    n_j = JW'(r_j + 1'b1);
                    n_rv = 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
                n_pv = r_rv;
                if (r_rv) begin
                    mul_a = 38'($signed({1'b0, r_hid_rd}));
                    mul_b = 18'(mem_rd);
                end
                if (r_pv) begin
                    n_acc = r_acc + ACCW'(r_prod);
                end
                if (r_j == JW'(H) && !r_rv && !r_pv) begin
                    n_state = S_OF;
                end
            end
            S_OF: begin
                q16 = f_sat16(f_rnd(64'(r_acc), 12));
                if (r_k == '0 || q16 > r_bestq) begin
                    n_best = r_k[KW-1:0];
                    n_bestq = q16;
                end
                if (r_k[KW-1:0] == r_tgt) begin
                    n_selq = q16;
                end
                n_k = KCW'(r_k + 1'b1);
                if (r_k == KCW'(A - 1)) begin
                    n_state = S_DEC;
                end else begin
                    n_state = S_OB;
                end
            end
            S_DEC: begin
                if (r_req == tmq_pkg::REQ_CHOOSE) begin
                    expl = r_rfrac < r_eps;
                    n_res_exp = expl;
                    n_res_act = expl ? 4'(r_tgt) : 4'(r_best);
                    n_res_q = expl ? r_selq : r_bestq;
                    n_state = S_DONE;
                end else begin
                    n_res_q = r_selq;
                    n_err = 17'(r_reward) - 17'(r_selq);
                    n_state = S_L0;
                end
            end
            S_L0: begin
                mul_a = 38'(r_err);
                mul_b = $signed({2'b00, r_lr});
                mem_ra = AW'(BASE_B2) + AW'(r_tgt);
                n_state = S_L1;
            end
            S_L1: begin
                mem_we = 1'b1;
                mem_wa = AW'(BASE_B2) + AW'(r_tgt);
                mem_wd = f_sat16(64'(mem_rd) + f_rnd(64'(r_prod), 16));
                n_le = r_prod[33:0];
                n_j = '0;
                n_state = S_W2R;
            end
            S_W2R: begin
                n_state = S_W2M;
            end
            S_W2M: begin
                n_wold = mem_rd;
                n_h = r_hid_rd;
                mul_a = 38'(r_le);
                mul_b = 18'($signed({1'b0, r_hid_rd}));
                n_state = S_W2W;
            end
            S_W2W: begin
                mem_we = 1'b1;
                mem_wd = f_sat16(64'(r_wold) + f_rnd(64'(r_prod), 28));
                n_wnew = mem_wd;
                n_state = S_G;
            end
            S_G: begin
                mul_a = 38'(r_err);
                mul_b = 18'(r_wnew);
                n_state = S_G2;
            end
            S_G2: begin
                if (r_h != '0) begin
                    grad = 22'(f_rnd(64'(r_prod), 12));
                end
                mul_a = 38'(grad);
                mul_b = $signed({2'b00, r_lr});
                n_state = S_G3;
            end
            S_G3: begin
                n_lg = r_prod[37:0];
                mem_ra = AW'(rj);
                n_state = S_M0;
            end
            S_M0: begin
                n_wold = mem_rd;
                mul_a = r_lg;
                mul_b = 18'(r_in0);
                n_state = S_W0;
            end
            S_W0: begin
                mem_we = 1'b1;
                mem_wa = AW'(rj);
                mem_wd = f_sat16(64'(r_wold) + f_rnd(64'(r_prod), 28));
                mem_ra = AW'(H) + AW'(rj);
                n_state = S_M1;
            end
            S_M1: begin
                n_wold = mem_rd;
                mul_a = r_lg;
                mul_b = 18'(r_in1);
                n_state = S_W1;
            end
            S_W1: begin
                mem_we = 1'b1;
                mem_wa = AW'(H) + AW'(rj);
                mem_wd = f_sat16(64'(r_wold) + f_rnd(64'(r_prod), 28));
                mem_ra = AW'(BASE_B1) + AW'(rj);
                n_state = S_BW;
            end
            S_BW: begin
                mem_we = 1'b1;
                mem_wa = AW'(BASE_B1) + AW'(rj);
                mem_wd = f_sat16(64'(mem_rd) + f_rnd(64'(r_lg), 16));
                n_j = JW'(r_j + 1'b1);
                if (r_j == JW'(H - 1)) begin
                    n_state = S_EPS;
                end else begin
                    n_state = S_W2R;
                end
            end
            S_EPS: begin
                if (r_eps > tmq_pkg::EPS_FLOOR) begin
                    n_eps = 16'((32'(r_eps) * tmq_pkg::EPS_DECAY + 32'd32768) >> 16);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov = 1'b1;
                    n_oact = r_res_act;
                    n_oq = r_res_q;
                    n_oexp = r_res_exp;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_eps   <= tmq_pkg::EPS_RESET;
            r_ctr   <= 16'sd0;
            r_tsc   <= 16'd256;
            r_plim  <= 15'd3000;
            r_psc   <= 16'd22;
            r_lr    <= 16'd66;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_eps   <= n_eps;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tmq_pkg::CFG_CENTER_TEMP: r_ctr  <= $signed(i_cfg_data);
                    tmq_pkg::CFG_TEMP_SCALE:  r_tsc  <= i_cfg_data;
                    tmq_pkg::CFG_POWER_LIMIT: r_plim <= i_cfg_data[14:0];
                    tmq_pkg::CFG_POWER_SCALE: r_psc  <= i_cfg_data;
                    tmq_pkg::CFG_LEARN_RATE:  r_lr   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;         r_temp <= n_temp;     r_pwr <= n_pwr;
        r_act <= n_act;         r_reward <= n_reward; r_rfrac <= n_rfrac;
        r_tgt <= n_tgt;         r_in0 <= n_in0;       r_in1 <= n_in1;
        r_j <= n_j;             r_k <= n_k;           r_acc <= n_acc;
        r_prod <= mul_a * mul_b;
        r_rv <= n_rv;           r_pv <= n_pv;         r_best <= n_best;
        r_bestq <= n_bestq;     r_selq <= n_selq;     r_err <= n_err;
        r_le <= n_le;           r_wold <= n_wold;     r_wnew <= n_wnew;
        r_h <= n_h;             r_lg <= n_lg;
        r_res_act <= n_res_act; r_res_q <= n_res_q;   r_res_exp <= n_res_exp;
        r_oact <= n_oact;       r_oq <= n_oq;         r_oexp <= n_oexp;
    end

    a_eps_only_in_decay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_eps != $past(r_eps)) |-> $past(r_state) == S_EPS)
        else $error("epsilon changed outside the decay step");

    a_eps_never_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_eps <= $past(r_eps))
        else $error("epsilon increased");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state) == S_DONE)
        else $error("result raised outside the done step");

    a_idle_write_only_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && mem_we) |-> (in_acc && i_in.req_type == tmq_pkg::REQ_WRITE))
        else $error("weight memory written in idle without a write request");

endmodule

>>> rtl/tmq_wram.sv
// Weight memory: one write port, one registered read port.
module tmq_wram #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_wa,
    input  logic signed [tmq_pkg::DATA_W-1:0] i_wd,
    input  logic [AW-1:0]                     i_ra,
    output logic signed [tmq_pkg::DATA_W-1:0] o_rd
);
    logic signed [tmq_pkg::DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end
endmodule

>>> test/tiny_mlp_q_learner_tb.sv
// Testbench of the tiny MLP Q-learner: directed and random requests checked against a cycle-free predictor.
module tiny_mlp_q_learner_tb;

    localparam int HU = tmq_pkg::HIDDEN_UNITS_DEF;
    localparam int AC = tmq_pkg::ACTION_COUNT_DEF;
    localparam int WEIGHT_TOTAL = 3 * HU + HU * AC + AC;
    localparam int STALL_LIMIT = 6000;

    typedef struct {
        tmq_pkg::t_req            kind;
        logic signed [15:0]       temp;
        logic signed [15:0]       pwr;
        logic [3:0]               act;
        logic signed [15:0]       reward;
        logic [15:0]              rfrac;
        logic [3:0]               ract;
        logic [7:0]               widx;
        logic signed [15:0]       wval;
    } t_request;

    typedef struct {
        logic [3:0]         act;
        logic signed [15:0] q;
        logic               explored;
    } t_decision;

    class q_scoreboard;
        longint w1[2*HU];
        longint b1[HU];
        longint w2[HU*AC];
        longint b2[AC];
        longint eps;
        longint ctr_temp, t_scale, p_limit, p_scale, l_rate;
        longint net[2];
        longint hid[HU];
        longint outq[AC];
        t_decision pending[$];
        int errors;

        function void clear();
            eps = 65535; ctr_temp = 0; t_scale = 256; p_limit = 3000; p_scale = 22;
            l_rate = 66; errors = 0;
        endfunction

        function longint rnd(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void set_reg(tmq_pkg::t_cfg_idx idx, logic [15:0] d);
            case (idx)
                tmq_pkg::CFG_CENTER_TEMP: ctr_temp = longint'($signed(d));
                tmq_pkg::CFG_TEMP_SCALE:  t_scale = d;
                tmq_pkg::CFG_POWER_LIMIT: p_limit = d[14:0];
                tmq_pkg::CFG_POWER_SCALE: p_scale = d;
                tmq_pkg::CFG_LEARN_RATE:  l_rate = d;
                default: ;
            endcase
        endfunction

        function void forward(longint temp, longint pwr);
            longint acc;
            net[0] = clip(rnd((temp - ctr_temp) * t_scale, 4), -4096, 4096);
            net[1] = clip(rnd(clip(pwr, -p_limit, p_limit) * p_scale, 4), -32768, 32767);
            for (int j = 0; j < HU; j++) begin
                acc = b1[j] * 4096 + net[0] * w1[j] + net[1] * w1[HU + j];
                hid[j] = clip(rnd(acc, 12), 0, 32767);
            end
            for (int k = 0; k < AC; k++) begin
                acc = b2[k] * 4096;
                for (int j = 0; j < HU; j++) acc += hid[j] * w2[j*AC + k];
                outq[k] = clip(rnd(acc, 12), -32768, 32767);
            end
        endfunction

        function void note(t_request r);
            t_decision d;
            longint err, grad;
            int best;
            d.act = r.act; d.q = 0; d.explored = 0;
            if (r.kind == tmq_pkg::REQ_CHOOSE) begin
                forward(r.temp, r.pwr);
                if (longint'(r.rfrac) < eps) begin
                    d.act = 4'(r.ract % AC);
                    d.explored = 1;
                end else begin
                    best = 0;
                    for (int k = 1; k < AC; k++) if (outq[k] > outq[best]) best = k;
                    d.act = 4'(best);
                end
                d.q = 16'(outq[d.act]);
            end else if (r.kind == tmq_pkg::REQ_TRAIN && r.act < AC) begin
                forward(r.temp, r.pwr);
                d.q = 16'(outq[r.act]);
                err = longint'(r.reward) - outq[r.act];
                for (int j = 0; j < HU; j++)
                    w2[j*AC + r.act] = clip(w2[j*AC + r.act] + rnd(l_rate * err * hid[j], 28),
                                            -32768, 32767);
                b2[r.act] = clip(b2[r.act] + rnd(l_rate * err, 16), -32768, 32767);
                for (int j = 0; j < HU; j++) begin
                    grad = hid[j] > 0 ? rnd(err * w2[j*AC + r.act], 12) : 0;
                    for (int i = 0; i < 2; i++)
                        w1[i*HU + j] = clip(w1[i*HU + j] + rnd(l_rate * grad * net[i], 28),
                                            -32768, 32767);
                    b1[j] = clip(b1[j] + rnd(l_rate * grad, 16), -32768, 32767);
                end
                if (eps > 3276) eps = (eps * 65503 + 32768) >> 16;
            end else if (r.kind == tmq_pkg::REQ_WRITE) begin
                if (r.widx < 2*HU) w1[r.widx] = r.wval;
                else if (r.widx < 3*HU) b1[r.widx - 2*HU] = r.wval;
                else if (r.widx < 3*HU + HU*AC) w2[r.widx - 3*HU] = r.wval;
                else if (r.widx < WEIGHT_TOTAL) b2[r.widx - 3*HU - HU*AC] = r.wval;
            end
            pending.push_back(d);
        endfunction

        function void check(t_decision got);
            t_decision want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result act=%0d q=%0d exp=%0b",
                                           got.act, got.q, got.explored);
                return;
            end
            want = pending.pop_front();
            if (got.act !== want.act || got.q !== want.q || got.explored !== want.explored) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: act %0d/%0d q %0d/%0d explored %0b/%0b (expected/actual)",
                             want.act, got.act, want.q, got.q, want.explored, got.explored);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tmq_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [tmq_pkg::DATA_W-1:0] i_cfg_data = '0;
    logic calm = 1'b0;
    int quiet_cycles = 0;
    q_scoreboard sb;

    tmq_in_if  req_if ();
    tmq_out_if res_if ();

    tiny_mlp_q_learner dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (req_if.sink),
        .o_out     (res_if.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0; req_if.req_type = '0; req_if.temperature = '0; req_if.power = '0;
        req_if.taken_action = '0; req_if.reward = '0; req_if.random_fraction = '0;
        req_if.random_action = '0; req_if.weight_index = '0; req_if.weight_value = '0;
        res_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check('{act: res_if.chosen_action, q: res_if.q_value, explored: res_if.explored});
        res_if.ready <= calm || ($urandom_range(0, 99) >= 12);
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send(t_request r);
        if (!calm && $urandom_range(0, 99) < 12) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= r.kind;
        req_if.temperature <= r.temp;
        req_if.power <= r.pwr;
        req_if.taken_action <= r.act;
        req_if.reward <= r.reward;
        req_if.random_fraction <= r.rfrac;
        req_if.random_action <= r.ract;
        req_if.weight_index <= r.widx;
        req_if.weight_value <= r.wval;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note(r);
    endtask

    function automatic t_request noise();
        t_request r;
        r.kind = tmq_pkg::REQ_CHOOSE; r.temp = 16'($urandom); r.pwr = 16'($urandom);
        r.act = 4'($urandom); r.reward = 16'($urandom); r.rfrac = 16'($urandom);
        r.ract = 4'($urandom); r.widx = 8'($urandom); r.wval = 16'($urandom);
        return r;
    endfunction

    task automatic write_weight(int idx, logic signed [15:0] val);
        t_request r;
        r = noise();
        r.kind = tmq_pkg::REQ_WRITE; r.widx = 8'(idx); r.wval = val;
        send(r);
    endtask

    task automatic load_weights();
        for (int i = 0; i < WEIGHT_TOTAL; i++)
            write_weight(i, $urandom_range(0, 99) < 8 ? 16'($urandom)
                                                      : 16'($urandom_range(0, 4095) - 2048));
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_reg(tmq_pkg::t_cfg_idx idx, logic [15:0] d);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, d);
        @(posedge i_clk);
    endtask

    task automatic set_all(logic [15:0] ct, logic [15:0] ts, logic [15:0] pl,
                           logic [15:0] ps, logic [15:0] lr);
        set_reg(tmq_pkg::CFG_CENTER_TEMP, ct);
        set_reg(tmq_pkg::CFG_TEMP_SCALE, ts);
        set_reg(tmq_pkg::CFG_POWER_LIMIT, pl);
        set_reg(tmq_pkg::CFG_POWER_SCALE, ps);
        set_reg(tmq_pkg::CFG_LEARN_RATE, lr);
    endtask

    task automatic random_phase(int count);
        t_request r;
        int pick;
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 2) && (n < count / 2 + 40);
            r = noise();
            pick = $urandom_range(0, 99);
            if (pick < 40) r.kind = tmq_pkg::REQ_CHOOSE;
            else if (pick < 75) begin
                r.kind = tmq_pkg::REQ_TRAIN;
                if ($urandom_range(0, 9) != 0) r.act = 4'($urandom_range(0, AC - 1));
            end else if (pick < 95) r.kind = tmq_pkg::REQ_WRITE;
            else r.kind = tmq_pkg::REQ_NONE;
            if (r.kind == tmq_pkg::REQ_CHOOSE && $urandom_range(0, 1)) r.rfrac = 16'hFFFF;
            send(r);
        end
        calm = 1'b0;
    endtask

    initial begin
        t_request r;
        sb = new();
        sb.clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_weights();
        r = noise();
        r.kind = tmq_pkg::REQ_CHOOSE; r.temp = 16'sh7FFF; r.pwr = 16'sh8000; r.rfrac = 16'hFFFF;
        send(r);
        r.temp = 16'sh8000; r.pwr = 16'sh7FFF; send(r);
        r.rfrac = 16'h0000; r.ract = 4'hF; send(r);
        r.temp = '0; r.pwr = '0; r.rfrac = 16'hFFFE; send(r);
        for (int a = 0; a < AC; a++) begin
            r.kind = tmq_pkg::REQ_TRAIN; r.act = 4'(a); r.reward = a[0] ? 16'sh7FFF : 16'sh8000;
            send(r);
        end
        r.act = 4'hF; send(r);
        r.act = 4'(AC); send(r);
        r.kind = tmq_pkg::REQ_NONE; send(r);
        write_weight(255, 16'sh7FFF);
        write_weight(WEIGHT_TOTAL, 16'sh1234);
        write_weight(WEIGHT_TOTAL - 1, 16'sh8000);
        write_weight(0, 16'sh7FFF);
        r.kind = tmq_pkg::REQ_CHOOSE; r.rfrac = 16'hFFFF; send(r);
        random_phase(120);
        drain();

        set_all(16'h8000, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
        load_weights();
        random_phase(90);
        drain();

        set_all(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
        load_weights();
        random_phase(90);
        drain();

        set_all(16'h0000, 16'd256, 16'd0, 16'd22, 16'd66);
        load_weights();
        random_phase(70);
        drain();

        for (int p = 0; p < 3; p++) begin
            set_all(16'($urandom), 16'($urandom_range(0, 2048)), 16'($urandom_range(1, 32767)),
                    16'($urandom), 16'($urandom_range(0, 4096)));
            load_weights();
            random_phase(85);
            drain();
        end

        repeat (400) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
